[src/pl0_style_lexer_defines.svh]
// Assertion macros for the lexer checker.
// Both expect aclk and aresetn in the scope where they are used.
`ifndef PL0_STYLE_LEXER_DEFINES_SVH
`define PL0_STYLE_LEXER_DEFINES_SVH

// Same-cycle implication.
`define PL0_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PL0_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/pl0_lex_pkg.sv]
package pl0_lex_pkg;

    localparam int NAME_CHARS  = 8;   // 5..8
    localparam int NUMBER_BITS = 32;  // 8..32
    localparam int TEXT_W      = 64;
    localparam int VALUE_W     = 32;
    localparam int LEN_W       = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int KW_COUNT    = 11;

    typedef enum logic [4:0] {
        K_END        = 5'd0,
        K_CONST      = 5'd1,
        K_BEGIN_END  = 5'd2,
        K_IF_GROUP   = 5'd3,
        K_WHILE_DO   = 5'd4,
        K_VAR        = 5'd5,
        K_READ_WRITE = 5'd6,
        K_IDENT      = 5'd7,
        K_NUMBER     = 5'd8,
        K_ASSIGN     = 5'd9,
        K_RELOP      = 5'd10,
        K_ADDOP      = 5'd11,
        K_MULOP      = 5'd12,
        K_BRACKET    = 5'd13,
        K_COMMA      = 5'd14,
        K_SEMI       = 5'd15,
        K_ERROR      = 5'd16
    } kind_t;

    localparam logic [2:0] V_NONE         = 3'd0;
    localparam logic [2:0] V_SECOND       = 3'd1;
    localparam logic [2:0] V_THIRD        = 3'd2;
    localparam logic [2:0] V_REL_LT       = 3'd0;
    localparam logic [2:0] V_REL_LE       = 3'd1;
    localparam logic [2:0] V_REL_NE       = 3'd2;
    localparam logic [2:0] V_REL_GT       = 3'd3;
    localparam logic [2:0] V_REL_GE       = 3'd4;
    localparam logic [2:0] V_REL_EQ       = 3'd5;
    localparam logic [2:0] V_ERR_BAD_CHAR = 3'd0;
    localparam logic [2:0] V_ERR_NUM_LTR  = 3'd1;

    typedef enum logic [3:0] {
        CC_SPACE,
        CC_LETTER,
        CC_DIGIT,
        CC_LT,
        CC_GT,
        CC_EQ,
        CC_SIMPLE,
        CC_END,
        CC_BAD
    } char_class_t;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NAME,
        MODE_NUM,
        MODE_LT,
        MODE_GT,
        MODE_EQ,
        MODE_HALT
    } scan_mode_t;

    // Classified character as it sits in the queue.
    typedef struct packed {
        logic [7:0]  char_code;
        char_class_t cls;
        kind_t       kind;      // single-char token kind for CC_SIMPLE/END/BAD
        logic [2:0]  variant;
    } char_item_t;

    typedef struct packed {
        kind_t              kind;
        logic [2:0]         variant;
        logic [VALUE_W-1:0] number_value;
        logic               number_saturated;
        logic [TEXT_W-1:0]  name_text;
        logic [LEN_W-1:0]   name_length;
        logic               last_of_run;
    } token_t;

    typedef struct packed {
        logic       hit;
        kind_t      kind;
        logic [2:0] variant;
    } kw_hit_t;

    // Keyword text packed first character in the low byte.
    localparam logic [TEXT_W-1:0] KW_TEXT [KW_COUNT] = '{
        64'h0000_0074_736E_6F43,  // Const
        64'h0000_006E_6967_6562,  // begin
        64'h0000_0000_0064_6E65,  // end
        64'h0000_0000_0000_6669,  // if
        64'h0000_0000_6E65_6874,  // then
        64'h0000_0000_6573_6C65,  // else
        64'h0000_0065_6C69_6877,  // while
        64'h0000_0000_0000_6F64,  // do
        64'h0000_0000_0072_6156,  // Var
        64'h0000_0000_6461_6572,  // read
        64'h0000_0065_7469_7277   // write
    };
    localparam logic [LEN_W-1:0] KW_LEN [KW_COUNT] = '{
        4'd5, 4'd5, 4'd3, 4'd2, 4'd4, 4'd4, 4'd5, 4'd2, 4'd3, 4'd4, 4'd5
    };
    localparam kind_t KW_KIND [KW_COUNT] = '{
        K_CONST, K_BEGIN_END, K_BEGIN_END, K_IF_GROUP, K_IF_GROUP, K_IF_GROUP,
        K_WHILE_DO, K_WHILE_DO, K_VAR, K_READ_WRITE, K_READ_WRITE
    };
    localparam logic [2:0] KW_VAR [KW_COUNT] = '{
        V_NONE, V_NONE, V_SECOND, V_NONE, V_SECOND, V_THIRD,
        V_NONE, V_SECOND, V_NONE, V_NONE, V_SECOND
    };

    function automatic kw_hit_t kw_lookup(input logic [TEXT_W-1:0] text,
                                          input logic [LEN_W-1:0]  len);
        kw_hit_t r;
        r.hit     = 1'b0;
        r.kind    = K_IDENT;
        r.variant = V_NONE;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (!r.hit && len == KW_LEN[i] && text == KW_TEXT[i]) begin
                r.hit     = 1'b1;
                r.kind    = KW_KIND[i];
                r.variant = KW_VAR[i];
            end
        end
        return r;
    endfunction

    function automatic token_t simple_token(input kind_t k, input logic [2:0] v);
        token_t t;
        t                  = '0;
        t.kind             = k;
        t.variant          = v;
        return t;
    endfunction

    function automatic char_item_t classify(input logic [7:0] c);
        char_item_t r;
        r.char_code = c;
        r.cls       = CC_BAD;
        r.kind      = K_ERROR;
        r.variant   = V_ERR_BAD_CHAR;
        if (c == 8'h20 || c == 8'h0A || c == 8'h09) begin
            r.cls = CC_SPACE;
        end else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)) begin
            r.cls = CC_LETTER;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r.cls = CC_DIGIT;
        end else begin
            case (c)
                8'h3C: r.cls = CC_LT;
                8'h3E: r.cls = CC_GT;
                8'h3D: r.cls = CC_EQ;
                8'h2B: begin r.cls = CC_SIMPLE; r.kind = K_ADDOP;   r.variant = V_NONE;   end
                8'h2D: begin r.cls = CC_SIMPLE; r.kind = K_ADDOP;   r.variant = V_SECOND; end
                8'h2A: begin r.cls = CC_SIMPLE; r.kind = K_MULOP;   r.variant = V_NONE;   end
                8'h2F: begin r.cls = CC_SIMPLE; r.kind = K_MULOP;   r.variant = V_SECOND; end
                8'h28: begin r.cls = CC_SIMPLE; r.kind = K_BRACKET; r.variant = V_NONE;   end
                8'h29: begin r.cls = CC_SIMPLE; r.kind = K_BRACKET; r.variant = V_SECOND; end
                8'h2C: begin r.cls = CC_SIMPLE; r.kind = K_COMMA;   r.variant = V_NONE;   end
                8'h3B: begin r.cls = CC_SIMPLE; r.kind = K_SEMI;    r.variant = V_NONE;   end
                8'h23: begin r.cls = CC_END;    r.kind = K_END;     r.variant = V_NONE;   end
                default: r.cls = CC_BAD;
            endcase
        end
        return r;
    endfunction

endpackage

[src/pl0_lex_front.sv]
// Front end: classify each accepted character and queue it for the scanner.
module pl0_lex_front
    import pl0_lex_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_code,
    output logic       q_valid,
    output char_item_t q_item,
    input  logic       q_pop
);

    char_item_t        queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;

    assign s_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != '0);
    assign q_item  = queue_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= classify(s_char_code);
        end
    end

endmodule

[src/pl0_lex_back.sv]
// Back end: scan state, token building, output register plus one overflow slot.
module pl0_lex_back
    import pl0_lex_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  char_item_t q_item,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output token_t     m_tok
);

    scan_mode_t             mode_reg, mode_next, start_mode;
    logic [TEXT_W-1:0]      name_buf_reg, name_buf_next;
    logic [LEN_W-1:0]       name_cnt_reg, name_cnt_next;
    logic [NUMBER_BITS-1:0] acc_reg, acc_next;
    logic                   ovf_reg, ovf_next;
    logic                   m_valid_reg, m_valid_next;
    token_t                 m_tok_reg, m_tok_next;
    logic                   pend_valid_reg, pend_valid_next;
    token_t                 pend_tok_reg, pend_tok_next;

    token_t                 start_tok, first_tok, tok0, tok1;
    logic                   start_emit, first_emit, use_start;
    logic                   emit_one, emit_two;
    logic                   out_free;
    logic                   is_alnum;
    logic [NUMBER_BITS+3:0] acc_sum;
    kw_hit_t                kw;

    localparam logic [NUMBER_BITS-1:0] NUM_MAX = {NUMBER_BITS{1'b1}};

    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = q_valid && !pend_valid_reg && out_free;
    assign m_valid  = m_valid_reg;
    assign m_tok    = m_tok_reg;
    assign is_alnum = (q_item.cls == CC_LETTER) || (q_item.cls == CC_DIGIT);

    // acc*10 + digit
    assign acc_sum = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                   + (NUMBER_BITS + 4)'(q_item.char_code[3:0]);
    assign kw = kw_lookup(name_buf_reg, name_cnt_reg);

    // Token start for the current character, used when that character begins a new token.
    always_comb begin
        start_emit = 1'b0;
        start_tok  = simple_token(q_item.kind, q_item.variant);
        start_mode = MODE_IDLE;
        case (q_item.cls)
            CC_LETTER: start_mode = MODE_NAME;
            CC_DIGIT:  start_mode = MODE_NUM;
            CC_LT:     start_mode = MODE_LT;
            CC_GT:     start_mode = MODE_GT;
            CC_EQ:     start_mode = MODE_EQ;
            CC_SIMPLE: start_emit = 1'b1;
            CC_END,
            CC_BAD: begin
                start_emit = 1'b1;
                start_mode = MODE_HALT;
            end
            default:   start_mode = MODE_IDLE;
        endcase
    end

    always_comb begin
        first_emit    = 1'b0;
        first_tok     = simple_token(K_ERROR, V_NONE);
        use_start     = 1'b0;
        mode_next     = mode_reg;
        name_buf_next = name_buf_reg;
        name_cnt_next = name_cnt_reg;
        acc_next      = acc_reg;
        ovf_next      = ovf_reg;

        case (mode_reg)
            MODE_IDLE: use_start = 1'b1;
            MODE_NAME: begin
                if (is_alnum) begin
                    if (name_cnt_reg < LEN_W'(NAME_CHARS)) begin
                        name_buf_next = name_buf_reg
                                      | (TEXT_W'(q_item.char_code) << {name_cnt_reg, 3'b000});
                    end
                    if (name_cnt_reg != '1) begin
                        name_cnt_next = name_cnt_reg + 1'b1;
                    end
                end else begin
                    first_emit            = 1'b1;
                    first_tok             = simple_token(kw.kind, kw.variant);
                    first_tok.name_text   = name_buf_reg;
                    first_tok.name_length = name_cnt_reg;
                    use_start             = 1'b1;
                end
            end
            MODE_NUM: begin
                if (q_item.cls == CC_DIGIT) begin
                    if (acc_sum[NUMBER_BITS+3:NUMBER_BITS] != '0) begin
                        acc_next = NUM_MAX;
                        ovf_next = 1'b1;
                    end else begin
                        acc_next = acc_sum[NUMBER_BITS-1:0];
                    end
                end else if (q_item.cls == CC_LETTER) begin
                    first_emit = 1'b1;
                    first_tok  = simple_token(K_ERROR, V_ERR_NUM_LTR);
                    mode_next  = MODE_HALT;
                end else begin
                    first_emit                 = 1'b1;
                    first_tok                  = simple_token(K_NUMBER, V_NONE);
                    first_tok.number_value     = VALUE_W'(acc_reg);
                    first_tok.number_saturated = ovf_reg;
                    use_start                  = 1'b1;
                end
            end
            MODE_LT: begin
                first_emit = 1'b1;
                if (q_item.cls == CC_GT) begin
                    first_tok = simple_token(K_RELOP, V_REL_NE);
                    mode_next = MODE_IDLE;
                end else if (q_item.cls == CC_EQ) begin
                    first_tok = simple_token(K_RELOP, V_REL_LE);
                    mode_next = MODE_IDLE;
                end else begin
                    first_tok = simple_token(K_RELOP, V_REL_LT);
                    use_start = 1'b1;
                end
            end
            MODE_GT: begin
                first_emit = 1'b1;
                if (q_item.cls == CC_EQ) begin
                    first_tok = simple_token(K_RELOP, V_REL_GE);
                    mode_next = MODE_IDLE;
                end else begin
                    first_tok = simple_token(K_RELOP, V_REL_GT);
                    use_start = 1'b1;
                end
            end
            MODE_EQ: begin
                first_emit = 1'b1;
                if (q_item.cls == CC_EQ) begin
                    first_tok = simple_token(K_RELOP, V_REL_EQ);
                    mode_next = MODE_IDLE;
                end else begin
                    first_tok = simple_token(K_ASSIGN, V_NONE);
                    use_start = 1'b1;
                end
            end
            default: mode_next = MODE_HALT;
        endcase

        if (use_start) begin
            mode_next = start_mode;
            if (q_item.cls == CC_LETTER) begin
                name_buf_next = TEXT_W'(q_item.char_code);
                name_cnt_next = LEN_W'(1);
            end
            if (q_item.cls == CC_DIGIT) begin
                acc_next = NUMBER_BITS'(q_item.char_code[3:0]);
                ovf_next = 1'b0;
            end
        end
    end

    // Order the zero, one or two tokens of this character.
    always_comb begin
        tok0     = first_tok;
        tok1     = start_tok;
        emit_two = first_emit && use_start && start_emit;
        emit_one = first_emit || (use_start && start_emit);
        if (!first_emit) begin
            tok0 = start_tok;
        end
        tok0.last_of_run = !emit_two;
        tok1.last_of_run = 1'b1;
    end

    always_comb begin
        m_valid_next    = m_valid_reg && !m_ready;
        m_tok_next      = m_tok_reg;
        pend_valid_next = pend_valid_reg;
        pend_tok_next   = pend_tok_reg;
        if (pend_valid_reg && out_free) begin
            m_valid_next    = 1'b1;
            m_tok_next      = pend_tok_reg;
            pend_valid_next = 1'b0;
        end else if (q_pop && emit_one) begin
            m_valid_next    = 1'b1;
            m_tok_next      = tok0;
            pend_valid_next = emit_two;
            pend_tok_next   = tok1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_IDLE;
            name_buf_reg   <= '0;
            name_cnt_reg   <= '0;
            acc_reg        <= '0;
            ovf_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                mode_reg     <= mode_next;
                name_buf_reg <= name_buf_next;
                name_cnt_reg <= name_cnt_next;
                acc_reg      <= acc_next;
                ovf_reg      <= ovf_next;
            end
            m_valid_reg    <= m_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tok_reg    <= m_tok_next;
        pend_tok_reg <= pend_tok_next;
    end

endmodule

[src/pl0_style_lexer.sv]
// PL/0-style lexer. One source byte per input beat on s_char_code; tokens come
// out one per beat on the m_ channel (kind, variant, number value and
// saturation flag, first eight name characters, name length, last_of_run).
// A character gives zero, one or two tokens; last_of_run marks the final
// token caused by a character.
// An accepted character goes into the queue and is scanned from there; its first
// token is registered into the output register by the edge that scans it.
// Throughput: one character per cycle while m_ready is high and each gives at most
// one token; a character that gives two tokens holds the scanner until the single
// output register has taken the second token from the spare token slot.
// A four-beat queue separates classification from scanning, so s_ready only
// drops when that queue is full; a stalled m_ready fills it and then stops
// input, with no token lost or repeated. The output beat holds while stalled.
// After the end mark '#' or an error token the scanner drops all further
// characters (they are still accepted) until reset.
// aresetn is synchronous and active low: it empties the queue, clears the
// output, and returns scanning to the between-tokens state.
module pl0_style_lexer
    import pl0_lex_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [7:0]   s_char_code,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [4:0]   m_token_kind,
    output logic [2:0]   m_variant,
    output logic [31:0]  m_number_value,
    output logic         m_number_saturated,
    output logic [63:0]  m_name_text,
    output logic [3:0]   m_name_length,
    output logic         m_last_of_run
);

    logic       q_valid;
    logic       q_pop;
    char_item_t q_item;
    token_t     m_tok;

    // classification plus character queue
    pl0_lex_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    // scanner and token output stage
    pl0_lex_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_tok   (m_tok)
    );

    assign m_token_kind       = m_tok.kind;
    assign m_variant          = m_tok.variant;
    assign m_number_value     = m_tok.number_value;
    assign m_number_saturated = m_tok.number_saturated;
    assign m_name_text        = m_tok.name_text;
    assign m_name_length      = m_tok.name_length;
    assign m_last_of_run      = m_tok.last_of_run;

endmodule

[src/pl0_lex_checker.sv]
`include "pl0_style_lexer_defines.svh"

module pl0_lex_checker
    import pl0_lex_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         m_valid,
    input logic         m_ready,
    input logic [4:0]   m_token_kind,
    input logic [2:0]   m_variant,
    input logic [31:0]  m_number_value,
    input logic         m_number_saturated,
    input logic [63:0]  m_name_text,
    input logic [3:0]   m_name_length,
    input logic         m_last_of_run
);

    `PL0_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_token_kind) && $stable(m_variant) && $stable(m_last_of_run), "stalled token beat changed")

    `PL0_ASSERT_NEXT(a_halt_quiet, m_valid && m_ready && (m_token_kind == K_END || m_token_kind == K_ERROR), !m_valid, "token after end or error")

    `PL0_ASSERT_NOW(a_value_only_number, m_valid && m_token_kind != K_NUMBER, m_number_value == 32'd0 && !m_number_saturated, "number fields set on non-number token")

    `PL0_ASSERT_NOW(a_text_only_name, m_valid && (m_token_kind == K_END || m_token_kind >= K_NUMBER), m_name_text == 64'd0 && m_name_length == 4'd0, "name fields set on non-name token")

    `PL0_ASSERT_NOW(a_ident_length, m_valid && m_token_kind == K_IDENT, m_name_length != 4'd0 && m_name_text[7:0] != 8'd0, "empty identifier")

endmodule

bind pl0_style_lexer pl0_lex_checker u_pl0_lex_checker (.*);
